/* rtl/core/smd_pkg.sv */
package smd_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  // Largest result magnitude; results saturate to plus or minus this value.
  localparam logic [WORD_W-2:0] SAT_MAG = '1;

  // Status of a bit-serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } smd_sts_t;

endpackage

/* rtl/core/smd_mul.sv */
module smd_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [smd_pkg::WORD_W-1:0]      op_x,
  input  logic [smd_pkg::WORD_W-1:0]      op_y,
  output logic [2*smd_pkg::WORD_W-1:0]    prod,
  output smd_pkg::smd_sts_t               sts
);
  import smd_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

  logic [2*WORD_W-1:0] prod_r;
  logic [2*WORD_W-1:0] prod_nxt;
  logic [WORD_W-1:0]   mcand_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [WORD_W:0]     sum;

  // Shift-add: one multiplier bit is consumed per cycle from the low end.
  always_comb begin
    sum      = {1'b0, prod_r[2*WORD_W-1:WORD_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_nxt = {sum, prod_r[WORD_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= op_x;
      prod_r  <= {{WORD_W{1'b0}}, op_y};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod     = prod_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* rtl/core/smd_div.sv */
module smd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [smd_pkg::WORD_W-1:0]  dividend,
  input  logic [smd_pkg::WORD_W-1:0]  divisor,
  output logic [smd_pkg::WORD_W-1:0]  quo,
  output smd_pkg::smd_sts_t           sts
);
  import smd_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] dvsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WORD_W:0]   shifted;
  logic [WORD_W+1:0] diff;
  logic              ge;
  logic [WORD_W-1:0] rem_nxt;
  logic [WORD_W-1:0] quo_nxt;

  // Restoring division: the dividend leaves quo_r at the top while the
  // quotient bits enter at the bottom, one per cycle.
  always_comb begin
    shifted = {rem_r, quo_r[WORD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvsr_r};
    ge      = !diff[WORD_W+1];
    rem_nxt = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
    quo_nxt = {quo_r[WORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo      = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* rtl/core/scaled_muldiv_saturating.sv */
// Signed a*b/c with saturation to plus or minus 0x7FFFFFFF.
//
// Input channel: in_factor_a, in_factor_b and in_divisor travel as one item
// under in_valid / in_stall. The block works on one item at a time and
// holds in_stall high from the acceptance of an item until its result has
// been written into the output register; the next item can be taken in the
// cycle after that.
// Result channel: out_quotient under out_valid / out_stall. A finished
// result waits in the block while the output register is still occupied,
// and out_quotient holds while out_valid and out_stall are both high.
// Paths from acceptance to out_valid: a zero factor goes straight to the
// result; after the shift-add multiply the operands either saturate or,
// when the product fits in 32 bits, go through a restoring divide; else
// the scaled path normalizes, divides, multiplies and shifts back, and a
// product that overflows leaves the larger factor at most 15 bits of
// headroom. The bit-serial multiplier and divider work one bit per cycle;
// a stalled receiver delays out_valid further.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops
// out_valid and idles the multiplier and divider; datapath registers are not reset.
module scaled_muldiv_saturating (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [smd_pkg::WORD_W-1:0] in_factor_a,
  input  logic signed [smd_pkg::WORD_W-1:0] in_factor_b,
  input  logic signed [smd_pkg::WORD_W-1:0] in_divisor,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [smd_pkg::WORD_W-1:0] out_quotient
);
  import smd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL_AB,
    S_DIV_EX,
    S_LZ,
    S_RS,
    S_DIV_MG,
    S_MUL_QS,
    S_SHR,
    S_FINISH
  } state_t;

  function automatic logic [WORD_W-1:0] mag_of(input logic [WORD_W-1:0] x);
    mag_of = x[WORD_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [WORD_W-1:0] signed_res(input logic neg,
                                                   input logic [WORD_W-2:0] mag);
    signed_res = neg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
  endfunction

  state_t              state_r;
  logic [WORD_W-1:0]   ma_r;
  logic [WORD_W-1:0]   mb_r;
  logic [WORD_W-1:0]   mc_r;
  logic                neg_r;
  logic                sab_r;
  logic [WORD_W-1:0]   work_r;
  logic [WORD_W-1:0]   small_r;
  logic [WORD_W-1:0]   scan_r;
  logic [CNT_W-1:0]    left_r;
  logic [CNT_W-1:0]    right_r;
  logic [CNT_W-1:0]    shift_r;
  logic [2*WORD_W-1:0] prod_r;
  logic [WORD_W-1:0]   rslt_r;
  logic [WORD_W-1:0]   out_quotient_r;
  logic                out_valid_r;

  logic                in_acc;
  logic                zero_in;
  logic                mul_start;
  logic [WORD_W-1:0]   mul_x;
  logic [WORD_W-1:0]   mul_y;
  logic [2*WORD_W-1:0] mul_prod;
  smd_sts_t            mul_sts;
  logic                div_start;
  logic [WORD_W-1:0]   div_dvd;
  logic [WORD_W-1:0]   div_quo;
  smd_sts_t            div_sts;
  logic                fits;
  logic                exact_ok;
  logic                sat_early;
  logic                scan_gt;
  logic [WORD_W-2:0]   ex_mag;
  logic [WORD_W-2:0]   mg_mag;
  logic                out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign zero_in  = (in_factor_a == '0) || (in_factor_b == '0);
  assign out_free = !out_valid_r || !out_stall;

  // The product of the magnitudes is at most 2^62; it fits in a signed word
  // when below 2^31, or equal to 2^31 with a negative sign.
  always_comb begin
    fits = (mul_prod[2*WORD_W-1:WORD_W-1] == '0) ||
           (sab_r && (mul_prod[2*WORD_W-1:WORD_W-1] == (WORD_W+1)'(1)) &&
            (mul_prod[WORD_W-2:0] == '0));
    exact_ok  = fits && (mc_r != '0);
    sat_early = (mc_r == '0) || ma_r[WORD_W-1] || mb_r[WORD_W-1] || mc_r[WORD_W-1];
    scan_gt   = scan_r > mc_r;
    ex_mag    = div_quo[WORD_W-1] ? SAT_MAG : div_quo[WORD_W-2:0];
    mg_mag    = (prod_r[2*WORD_W-1:WORD_W-1] != '0) ? SAT_MAG : prod_r[WORD_W-2:0];
  end

  // One multiplier serves both products, one divider both quotients.
  always_comb begin
    mul_start = (state_r == S_LOAD) || ((state_r == S_DIV_MG) && div_sts.done);
    mul_x     = (state_r == S_LOAD) ? ma_r : div_quo;
    mul_y     = (state_r == S_LOAD) ? mb_r : small_r;
    div_start = ((state_r == S_MUL_AB) && mul_sts.done && exact_ok) ||
                ((state_r == S_RS) && !scan_gt && (right_r <= left_r));
    div_dvd   = (state_r == S_MUL_AB) ? mul_prod[WORD_W-1:0] : work_r;
  end

  smd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_x  (mul_x),
    .op_y  (mul_y),
    .prod  (mul_prod),
    .sts   (mul_sts)
  );

  smd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (mc_r),
    .quo      (div_quo),
    .sts      (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ma_r  <= mag_of(in_factor_a);
            mb_r  <= mag_of(in_factor_b);
            mc_r  <= mag_of(in_divisor);
            sab_r <= in_factor_a[WORD_W-1] ^ in_factor_b[WORD_W-1];
            neg_r <= in_factor_a[WORD_W-1] ^ in_factor_b[WORD_W-1] ^ in_divisor[WORD_W-1];
            if (zero_in) begin
              rslt_r  <= '0;
              state_r <= S_FINISH;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state_r <= S_MUL_AB;
        end
        S_MUL_AB: begin
          if (mul_sts.done) begin
            if (exact_ok) begin
              state_r <= S_DIV_EX;
            end else if (sat_early) begin
              rslt_r  <= signed_res(neg_r, SAT_MAG);
              state_r <= S_FINISH;
            end else begin
              if (mb_r > ma_r) begin
                work_r  <= mb_r;
                small_r <= ma_r;
                scan_r  <= ma_r;
              end else begin
                work_r  <= ma_r;
                small_r <= mb_r;
                scan_r  <= mb_r;
              end
              left_r  <= '0;
              right_r <= '0;
              state_r <= S_LZ;
            end
          end
        end
        S_DIV_EX: begin
          if (div_sts.done) begin
            rslt_r  <= signed_res(neg_r, ex_mag);
            state_r <= S_FINISH;
          end
        end
        S_LZ: begin
          // Normalize the larger factor up to bit 30, counting the headroom.
          if (work_r[WORD_W-2]) begin
            state_r <= S_RS;
          end else begin
            work_r <= {work_r[WORD_W-2:0], 1'b0};
            left_r <= left_r + 1'b1;
          end
        end
        S_RS: begin
          // Each step right also undoes one step of the normalization, so
          // work_r ends as the larger factor shifted left by left - right.
          if (scan_gt) begin
            scan_r  <= {1'b0, scan_r[WORD_W-1:1]};
            work_r  <= {1'b0, work_r[WORD_W-1:1]};
            right_r <= right_r + 1'b1;
          end else if (right_r > left_r) begin
            rslt_r  <= signed_res(neg_r, SAT_MAG);
            state_r <= S_FINISH;
          end else begin
            shift_r <= left_r - right_r;
            state_r <= S_DIV_MG;
          end
        end
        S_DIV_MG: begin
          if (div_sts.done) begin
            state_r <= S_MUL_QS;
          end
        end
        S_MUL_QS: begin
          if (mul_sts.done) begin
            prod_r  <= mul_prod;
            state_r <= S_SHR;
          end
        end
        S_SHR: begin
          if (shift_r == '0) begin
            rslt_r  <= signed_res(neg_r, mg_mag);
            state_r <= S_FINISH;
          end else begin
            prod_r  <= {1'b0, prod_r[2*WORD_W-1:1]};
            shift_r <= shift_r - 1'b1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_quotient_r <= rslt_r;
            out_valid_r    <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_quotient = out_quotient_r;

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_sts.busy)
    else $error("multiplier started while busy");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_LOAD) || (state_r == S_FINISH))
    else $error("accepted item did not start");

  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) && out_valid_r && out_stall |=> state_r == S_FINISH)
    else $error("result left while output register was occupied");

  a_no_min_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_quotient_r != {1'b1, {(WORD_W-1){1'b0}}})
    else $error("result outside saturation range");

endmodule
